// File: hw/rtl/sec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier package
// Shared widths, command codes, transaction payloads and internal types.
// ----------------------------------------------------------------------------
package sec_pkg;

	// Default sizes of the learner table and the sample store.
	localparam int DEF_MAX_LEARNERS = 64;
	localparam int DEF_NUM_FEATURES = 16;
	localparam int DEF_SAMPLE_ROWS  = 4;

	// Fixed field widths of the transactions.
	localparam int CMD_W   = 2;
	localparam int ROW_W   = 2;
	localparam int FEAT_W  = 4;
	localparam int VALUE_W = 32;

	// Command codes carried in the cmd field.
	localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

	// Depth of the command queue between front and back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Decoded operation.
	typedef enum logic [1:0] {
		OP_NOP,
		OP_LOAD,
		OP_WRITE,
		OP_CLASSIFY
	} op_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_WALK,
		B_FINISH
	} back_state_t;

	// Input transaction payload.
	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [ROW_W-1:0]          row_index;
		logic [FEAT_W-1:0]         feat_sel;
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] weight;
	} item_t;

	// Result transaction payload.
	typedef struct packed {
		logic status;
		logic is_label;
		logic label_positive;
	} result_t;

	// Decoded command as it travels through the queue.
	typedef struct packed {
		op_t                       op;
		logic                      row_ok;
		logic                      feat_ok;
		logic [ROW_W-1:0]          row_index;
		logic [FEAT_W-1:0]         feat_sel;
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] weight;
	} cmd_entry_t;

	// One stored decision stump.
	typedef struct packed {
		logic [FEAT_W-1:0]         feat;
		logic signed [VALUE_W-1:0] thr;
		logic signed [VALUE_W-1:0] wt;
	} stump_t;

	// Status that the back end reports to the front end.
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// File: hw/rtl/sec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier stream interfaces
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface sec_item_if;
	import sec_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

interface sec_result_if;
	import sec_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

// File: hw/rtl/stump_ensemble_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier top level
// Weighted vote of decision stumps in signed Q16.16 with a decoupled front
// end and back end.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. Load learner,
// write feature and unused commands are handled from the back end idle state
// once the result register is free. A classify walks the learner table one
// stored stump per cycle through the learner memory and sample store read
// ports. A two-entry command queue lets new transactions be taken while a
// classify is running or a result waits at the output. After reset the
// sample store is cleared one entry a cycle, and no input transaction is
// taken until that pass is done.
module stump_ensemble_classifier_top #(
	parameter int MAX_LEARNERS = sec_pkg::DEF_MAX_LEARNERS,
	parameter int NUM_FEATURES = sec_pkg::DEF_NUM_FEATURES,
	parameter int SAMPLE_ROWS  = sec_pkg::DEF_SAMPLE_ROWS
) (
	input logic          clk,
	input logic          arst_n,
	sec_item_if.sink     items,
	sec_result_if.source results
);
	import sec_pkg::*;

	logic         q_valid;
	cmd_entry_t   q_entry;
	logic         q_pop;
	back_status_t back_status;

	// Front end: accept, decode and queue.
	sec_front #(
		.NUM_FEATURES (NUM_FEATURES),
		.SAMPLE_ROWS  (SAMPLE_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.back_status (back_status),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	// Back end: tables, vote walk and result register.
	sec_back #(
		.MAX_LEARNERS (MAX_LEARNERS),
		.NUM_FEATURES (NUM_FEATURES),
		.SAMPLE_ROWS  (SAMPLE_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.back_status (back_status),
		.results     (results)
	);

endmodule

// File: hw/rtl/sec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier front end
// Accepts input transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module sec_front #(
	parameter int NUM_FEATURES = sec_pkg::DEF_NUM_FEATURES,
	parameter int SAMPLE_ROWS  = sec_pkg::DEF_SAMPLE_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sec_item_if.sink             items,
	input  sec_pkg::back_status_t back_status,
	output logic                 q_valid,
	output sec_pkg::cmd_entry_t  q_entry,
	input  logic                 q_pop
);
	import sec_pkg::*;

	cmd_entry_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       cnt_q;
	cmd_entry_t              dec;
	logic                    push;

	// Decode the command and check the row and feature ranges.
	always_comb begin
		dec.row_ok    = 32'(items.data.row_index) < SAMPLE_ROWS;
		dec.feat_ok   = 32'(items.data.feat_sel) < NUM_FEATURES;
		dec.row_index = items.data.row_index;
		dec.feat_sel  = items.data.feat_sel;
		dec.value     = items.data.value;
		dec.weight    = items.data.weight;
		unique case (items.data.cmd)
			CMD_LOAD:     dec.op = OP_LOAD;
			CMD_WRITE:    dec.op = OP_WRITE;
			CMD_CLASSIFY: dec.op = OP_CLASSIFY;
			default:      dec.op = OP_NOP;
		endcase
	end

	// Nothing is taken while the sample store is being cleared.
	assign items.ready = !back_status.clearing && (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready;
	assign q_valid     = cnt_q != '0;
	assign q_entry     = queue_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

endmodule

// File: hw/rtl/sec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier back end
// Holds the learner table and sample store, runs the vote walk and drives
// the result register.
// ----------------------------------------------------------------------------
module sec_back #(
	parameter int MAX_LEARNERS = sec_pkg::DEF_MAX_LEARNERS,
	parameter int NUM_FEATURES = sec_pkg::DEF_NUM_FEATURES,
	parameter int SAMPLE_ROWS  = sec_pkg::DEF_SAMPLE_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  sec_pkg::cmd_entry_t   q_entry,
	output logic                  q_pop,
	output sec_pkg::back_status_t back_status,
	sec_result_if.source          results
);
	import sec_pkg::*;

	localparam int LADDR_W     = (MAX_LEARNERS > 1) ? $clog2(MAX_LEARNERS) : 1;
	localparam int CNT_W       = $clog2(MAX_LEARNERS + 1);
	localparam int STORE_DEPTH = SAMPLE_ROWS * NUM_FEATURES;
	localparam int SADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int ACC_W       = VALUE_W + CNT_W + 1;

	// Memories.
	stump_t                    lrn_mem [MAX_LEARNERS];
	logic signed [VALUE_W-1:0] store_mem [STORE_DEPTH];

	// Control state.
	back_state_t         state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [ROW_W-1:0]    row_q;
	logic                row_ok_q;
	logic [SADDR_W-1:0]  clr_cnt_q;
	logic                res_valid_q;
	result_t             res_q;

	// Walk pipeline.
	logic                      v_s1, v_s2;
	stump_t                    stump_s1;
	logic signed [VALUE_W-1:0] x_raw_s2;
	logic                      zero_s2;
	logic signed [VALUE_W-1:0] thr_s2;
	logic signed [VALUE_W-1:0] wt_s2;
	logic signed [ACC_W-1:0]   acc_q;

	// Sequencer outputs.
	logic                      res_free;
	logic                      res_load;
	result_t                   res_d;
	logic                      lrn_we;
	logic                      store_we;
	logic [SADDR_W-1:0]        store_waddr;
	logic signed [VALUE_W-1:0] store_wdata;
	logic                      issue;
	logic                      walk_start;

	// Stage 1 address and range check.
	logic                      rd_ok_s1;
	logic [SADDR_W-1:0]        rd_addr_s1;
	logic [SADDR_W-1:0]        wr_addr;
	logic signed [VALUE_W-1:0] x_s2;
	logic signed [ACC_W-1:0]   wt_ext_s2;
	logic                      full;

	assign res_free = !res_valid_q || results.ready;
	assign full     = count_q == CNT_W'(MAX_LEARNERS);
	assign wr_addr  = SADDR_W'(32'(q_entry.row_index) * NUM_FEATURES
		+ 32'(q_entry.feat_sel));

	assign rd_ok_s1   = row_ok_q && (32'(stump_s1.feat) < NUM_FEATURES);
	assign rd_addr_s1 = SADDR_W'(32'(row_q) * NUM_FEATURES + 32'(stump_s1.feat));

	// Features outside the store read as zero.
	assign x_s2      = zero_s2 ? '0 : x_raw_s2;
	assign wt_ext_s2 = {{(ACC_W - VALUE_W){wt_s2[VALUE_W-1]}}, wt_s2};

	assign back_status.clearing = state_q == B_CLEAR;
	assign results.valid        = res_valid_q;
	assign results.data         = res_q;

	// Next state and sequencer outputs.
	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		res_load    = 1'b0;
		res_d       = '0;
		lrn_we      = 1'b0;
		store_we    = 1'b0;
		store_waddr = wr_addr;
		store_wdata = q_entry.value;
		issue       = 1'b0;
		walk_start  = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				store_we    = 1'b1;
				store_waddr = clr_cnt_q;
				store_wdata = '0;
				if (clr_cnt_q == SADDR_W'(STORE_DEPTH - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					unique case (q_entry.op)
						OP_LOAD: begin
							if (res_free) begin
								q_pop        = 1'b1;
								res_load     = 1'b1;
								res_d.status = full;
								lrn_we       = !full;
							end
						end
						OP_WRITE: begin
							if (res_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
								store_we = q_entry.row_ok && q_entry.feat_ok;
							end
						end
						OP_CLASSIFY: begin
							q_pop      = 1'b1;
							walk_start = 1'b1;
							state_d    = B_WALK;
						end
						default: begin
							if (res_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
							end
						end
					endcase
				end
			end
			B_WALK: begin
				if (idx_q != count_q) begin
					issue = 1'b1;
				end else begin
					state_d = B_FINISH;
				end
			end
			B_FINISH: begin
				if (!v_s1 && !v_s2 && res_free) begin
					res_load             = 1'b1;
					res_d.is_label       = 1'b1;
					res_d.label_positive = !acc_q[ACC_W-1];
					state_d              = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters, pipeline valids, accumulator and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			clr_cnt_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
			row_q       <= '0;
			row_ok_q    <= 1'b0;
		end else begin
			if (state_q == B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (lrn_we) begin
				count_q <= count_q + 1'b1;
			end
			if (walk_start) begin
				idx_q    <= '0;
				acc_q    <= '0;
				row_q    <= q_entry.row_index;
				row_ok_q <= q_entry.row_ok;
			end else if (v_s2) begin
				if (x_s2 <= thr_s2) begin
					acc_q <= acc_q + wt_ext_s2;
				end else begin
					acc_q <= acc_q - wt_ext_s2;
				end
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Learner table: append on load, registered read during the walk.
	always_ff @(posedge clk) begin
		if (lrn_we) begin
			lrn_mem[count_q[LADDR_W-1:0]] <= '{feat: q_entry.feat_sel,
				thr: q_entry.value, wt: q_entry.weight};
		end
		if (issue) begin
			stump_s1 <= lrn_mem[idx_q[LADDR_W-1:0]];
		end
	end

	// Sample store: clear pass and feature writes, registered read in stage 1.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		if (v_s1 && rd_ok_s1) begin
			x_raw_s2 <= store_mem[rd_addr_s1];
		end
	end

	// Stage 2 stump fields.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			zero_s2 <= !rd_ok_s1;
			thr_s2  <= stump_s1.thr;
			wt_s2   <= stump_s1.wt;
		end
	end

endmodule

// File: hw/rtl/sec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stump ensemble classifier checker
// Port-level assertions on result ordering and result encoding.
// ----------------------------------------------------------------------------
module sec_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input sec_pkg::result_t result_data
);
	import sec_pkg::*;

	// Transactions accepted whose result has not yet been delivered.
	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result holds its valid and its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// No result without an accepted transaction that is still open.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 4'd0)
		else $error("result without a pending transaction");

	// Queue, execution slot and output register bound the open transactions.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd4)
		else $error("too many open transactions");

	// Only a classification carries a label, and a classification never reports full.
	a_label_encoding: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.is_label || !result_data.label_positive)
			&& !(result_data.is_label && result_data.status))
		else $error("bad result encoding");

endmodule

bind stump_ensemble_classifier_top sec_checker u_sec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (items.valid),
	.item_ready   (items.ready),
	.result_valid (results.valid),
	.result_ready (results.ready),
	.result_data  (results.data)
);
